// ===== rtl/fixed_pattern_search_replace_core_assert.svh =====
// Assertion macros used by the checker of the pattern search and replace core.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef FIXED_PATTERN_SEARCH_REPLACE_CORE_ASSERT_SVH
`define FIXED_PATTERN_SEARCH_REPLACE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FPSR_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fpsr assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define FPSR_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fpsr assertion failed");

`endif

// ===== rtl/fpsr_pkg.sv =====
// Shared types and constants of the pattern search and replace core.
// No dependencies.
package fpsr_pkg;

  localparam int unsigned WinLen = 12;

  // Window bytes, element 0 is the oldest byte.
  typedef logic [0:WinLen-1][7:0] win_t;
  typedef logic [0:WinLen-2][7:0] held_t;

  localparam logic [31:0] SigWord0 = 32'hBC02_4708;
  localparam logic [31:0] SigWord1 = 32'h0000_0001;
  localparam logic [31:0] SigWord2 = 32'h0000_0002;
  localparam win_t        SigPattern = {SigWord0, SigWord1, SigWord2};

  localparam logic [31:0] TitleHighReset = 32'h0000_0001;
  localparam logic [31:0] TitleLowReset  = 32'h0000_0002;

  typedef enum logic [1:0] {
    RegTitleHigh = 2'd0,
    RegTitleLow  = 2'd1
  } cfg_reg_e;

endpackage

// ===== rtl/fpsr_window_patch.sv =====
// Appends one byte to the held window, compares the full window with the signature
// and patches the title words on a hit. Combinational. Depends on fpsr_pkg.
module fpsr_window_patch import fpsr_pkg::*; (
  input  held_t       held_i,
  input  logic [3:0]  fill_i,
  input  logic [7:0]  byte_i,
  input  logic [31:0] title_high_i,
  input  logic [31:0] title_low_i,
  output win_t        win_o,
  output logic        hit_o
);

  win_t win_raw;
  logic full;

  assign full = (fill_i == 4'(WinLen - 1));

  always_comb begin
    for (int i = 0; i < WinLen - 1; i++) begin
      win_raw[i] = (fill_i == 4'(i)) ? byte_i : held_i[i];
    end
    win_raw[WinLen-1] = full ? byte_i : 8'h00;
  end

  assign hit_o = full && (win_raw == SigPattern);

  always_comb begin
    win_o = win_raw;
    if (hit_o) begin
      win_o[4:7]  = title_high_i;
      win_o[8:11] = title_low_i;
    end
  end

endmodule

// ===== rtl/fixed_pattern_search_replace_core.sv =====
// Byte-stream signature search and replace. One byte request is taken per cycle and a
// byte leaves once eleven newer bytes of the same image have arrived, through a one-entry
// output register. A final image byte with n bytes still held sends n + 1 bytes out; the
// first goes to the output register at once and the other n drain from a flush buffer at
// one byte per cycle while the output is not stalled, during which the input is stalled.
// The input also stalls while the output register is full and stalled.
module fixed_pattern_search_replace_core import fpsr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_image_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        out_last_o,
  output logic [15:0] matches_found_o
);

  logic [31:0] title_high_q, title_low_q;
  held_t       win_q, win_d;
  logic [3:0]  fill_q, fill_d;
  logic [15:0] cnt_q, cnt_d, cnt_inc;
  held_t       flush_buf_q, flush_buf_d;
  logic [3:0]  flush_cnt_q, flush_cnt_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_byte_q, out_byte_d;
  logic        out_last_q, out_last_d;
  logic [15:0] out_cnt_q, out_cnt_d;

  win_t win_new;
  logic hit;
  logic full;
  logic out_ready;
  logic flush_busy;
  logic in_acc;

  fpsr_window_patch u_patch (
    .held_i       (win_q),
    .fill_i       (fill_q),
    .byte_i       (data_byte_i),
    .title_high_i (title_high_q),
    .title_low_i  (title_low_q),
    .win_o        (win_new),
    .hit_o        (hit)
  );

  assign full       = (fill_q == 4'(WinLen - 1));
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign flush_busy = (flush_cnt_q != 4'd0);
  assign in_stall_o = flush_busy || !out_ready;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign cnt_inc    = (hit && (cnt_q != 16'hFFFF)) ? cnt_q + 16'd1 : cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      title_high_q <= TitleHighReset;
      title_low_q  <= TitleLowReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegTitleHigh: title_high_q <= cfg_data_i;
        RegTitleLow:  title_low_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    win_d       = win_q;
    fill_d      = fill_q;
    cnt_d       = cnt_q;
    flush_buf_d = flush_buf_q;
    flush_cnt_d = flush_cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    out_cnt_d   = out_cnt_q;
    priority if (in_acc && end_of_image_i) begin
      // Oldest byte goes out now, the rest of the window waits in the flush buffer.
      out_valid_d = 1'b1;
      out_byte_d  = win_new[0];
      out_last_d  = (fill_q == 4'd0);
      out_cnt_d   = cnt_inc;
      flush_buf_d = win_new[1:WinLen-1];
      flush_cnt_d = fill_q;
      fill_d      = 4'd0;
      cnt_d       = 16'd0;
    end else if (in_acc) begin
      cnt_d = cnt_inc;
      if (full) begin
        out_valid_d = 1'b1;
        out_byte_d  = win_new[0];
        out_last_d  = 1'b0;
        out_cnt_d   = cnt_inc;
        win_d       = win_new[1:WinLen-1];
      end else begin
        win_d  = win_new[0:WinLen-2];
        fill_d = fill_q + 4'd1;
      end
    end else if (flush_busy && out_ready) begin
      out_valid_d = 1'b1;
      out_byte_d  = flush_buf_q[0];
      out_last_d  = (flush_cnt_q == 4'd1);
      flush_buf_d = {flush_buf_q[1:WinLen-2], 8'h00};
      flush_cnt_d = flush_cnt_q - 4'd1;
    end else begin
      // Nothing to take in or drain; everything holds.
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q       <= '0;
      fill_q      <= 4'd0;
      cnt_q       <= 16'd0;
      flush_cnt_q <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      win_q       <= win_d;
      fill_q      <= fill_d;
      cnt_q       <= cnt_d;
      flush_cnt_q <= flush_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    flush_buf_q <= flush_buf_d;
    out_byte_q  <= out_byte_d;
    out_last_q  <= out_last_d;
    out_cnt_q   <= out_cnt_d;
  end

  assign out_valid_o     = out_valid_q;
  assign out_byte_o      = out_byte_q;
  assign out_last_o      = out_last_q;
  assign matches_found_o = out_cnt_q;

endmodule

// ===== rtl/fpsr_checker.sv =====
// Port-level checker of the pattern search and replace core, bound to the top level.
// Depends on fixed_pattern_search_replace_core_assert.svh.
`include "fixed_pattern_search_replace_core_assert.svh"

module fpsr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        end_of_image_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [7:0]  out_byte_o,
  input logic        out_last_o,
  input logic [15:0] matches_found_o
);

  // A stalled result request keeps its payload.
  `FPSR_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_byte_o))

  // The final byte of an image always produces a result in the next cycle.
  `FPSR_ASSERT_NXT(a_last_out, in_valid_i && !in_stall_o && end_of_image_i, out_valid_o)

  // Within one image the match count never decreases.
  `FPSR_ASSERT_IMP(a_cnt_mono, out_valid_o && !out_stall_i && !out_last_o ##1 out_valid_o,
                   matches_found_o >= $past(matches_found_o))

  // Input is refused while a result is stuck in the output register.
  `FPSR_ASSERT_IMP(a_stall_full, out_valid_o && out_stall_i, in_stall_o)

endmodule

bind fixed_pattern_search_replace_core fpsr_checker u_fpsr_checker (.*);
